// File: design/rtc_date_bcd_encoder_defines.svh
// Assertion macros used by the encoder design file.
`ifndef RTC_DATE_BCD_ENCODER_DEFINES_SVH
`define RTC_DATE_BCD_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDBE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rdbe_pkg.sv
`timescale 1ns / 1ps
package rdbe_pkg;

  localparam logic [7:0]  CENTURY_FLAG = 8'h80;
  localparam logic [11:0] CENTURY_YEAR = 12'd2000;
  localparam logic [11:0] YEAR_MIN     = 12'd1900;
  localparam logic [11:0] YEAR_MAX     = 12'd2099;
  localparam logic [5:0]  SEC_MAX      = 6'd59;
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [3:0]  MONTH_MAX    = 4'd11;

  typedef logic [7:0] bcd8_t;

  // Two BCD digits of a value 0..99; the tens digit comes from a reciprocal multiply.
  function automatic bcd8_t bcd2(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 14'(v) * 14'd103;
    tens = prod[13:10];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  // The term (3 * (m + 1)) / 5 for the shifted month 3..14.
  function automatic logic [3:0] month_term(input logic [3:0] m);
    logic [3:0] t;
    unique case (m)
      4'd3:    t = 4'd2;
      4'd4:    t = 4'd3;
      4'd5:    t = 4'd3;
      4'd6:    t = 4'd4;
      4'd7:    t = 4'd4;
      4'd8:    t = 4'd5;
      4'd9:    t = 4'd6;
      4'd10:   t = 4'd6;
      4'd11:   t = 4'd7;
      4'd12:   t = 4'd7;
      4'd13:   t = 4'd8;
      4'd14:   t = 4'd9;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

endpackage

// File: design/rtc_date_bcd_encoder.sv
// Pipeline: an accepted input beat passes through stages 1 to 4 in order to its output beat.
// Throughput: one beat per cycle while out_stall is low; four register stages with valid bits.
// A stalled output holds its beat, and the stages behind it fill before in_stall rises.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "rtc_date_bcd_encoder_defines.svh"
module rtc_date_bcd_encoder
  import rdbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [5:0] in_second,
  input  logic [5:0] in_minute,
  input  logic [4:0] in_hour,
  input  logic [4:0] in_day_of_month,
  input  logic [3:0] in_month_zero_based,
  input  logic [11:0] in_full_year,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_second_bcd,
  output logic [6:0] out_minute_bcd,
  output logic [5:0] out_hour_bcd,
  output logic [5:0] out_day_bcd,
  output logic [2:0] out_weekday_code,
  output logic [7:0] out_month_century_byte,
  output logic [7:0] out_year_bcd
);

  logic adv1, adv2, adv3, adv4;
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  // Stage 1: clamped fields.
  logic [5:0]  sec1_r, min1_r, sec1_nxt, min1_nxt;
  logic [4:0]  hr1_r, day1_r, hr1_nxt, day1_nxt;
  logic [3:0]  mon1_r, mon1_nxt;
  logic [11:0] yr1_r, yr1_nxt;

  // Stage 2: BCD bytes and the two partial sums of the weekday congruence.
  logic [6:0]  sec2_r, min2_r, sec2_nxt, min2_nxt;
  logic [5:0]  hr2_r, day2_r, hr2_nxt, day2_nxt;
  logic [7:0]  mon2_r, yrb2_r, mon2_nxt, yrb2_nxt;
  logic [6:0]  dsum2_r, dsum2_nxt;
  logic [11:0] ysum2_r, ysum2_nxt;

  // Stage 3: full congruence sum.
  logic [6:0]  sec3_r, min3_r;
  logic [5:0]  hr3_r, day3_r;
  logic [7:0]  mon3_r, yrb3_r;
  logic [11:0] sum3_r, sum3_nxt;

  // Stage 4: output register.
  logic [6:0]  sec4_r, min4_r;
  logic [5:0]  hr4_r, day4_r;
  logic [7:0]  mon4_r, yrb4_r;
  logic [2:0]  wd4_r, wd4_nxt;

  logic [3:0]  mon_one;
  logic [3:0]  mon_shift;
  logic [11:0] yr_shift;
  logic [11:0] yr_mod;
  logic [4:0]  cent_q;
  logic [2:0]  quad_q;
  logic [4:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  mod7;

  assign adv4     = !v4_r || !out_stall;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_comb begin
    v1_nxt = adv1 ? in_valid : v1_r;
    v2_nxt = adv2 ? v1_r : v2_r;
    v3_nxt = adv3 ? v2_r : v3_r;
    v4_nxt = adv4 ? v3_r : v4_r;
  end

  always_comb begin
    sec1_nxt = (in_second > SEC_MAX) ? SEC_MAX : in_second;
    min1_nxt = (in_minute > SEC_MAX) ? SEC_MAX : in_minute;
    hr1_nxt  = (in_hour > HOUR_MAX) ? HOUR_MAX : in_hour;
    day1_nxt = (in_day_of_month == 5'd0) ? 5'd1 : in_day_of_month;
    mon1_nxt = (in_month_zero_based > MONTH_MAX) ? MONTH_MAX : in_month_zero_based;
    priority if (in_full_year > YEAR_MAX) begin
      yr1_nxt = YEAR_MAX;
    end else if (in_full_year < YEAR_MIN) begin
      yr1_nxt = YEAR_MIN;
    end else begin
      yr1_nxt = in_full_year;
    end
  end

  always_comb begin
    mon_one = mon1_r + 4'd1;
    if (mon_one <= 4'd2) begin
      mon_shift = mon_one + 4'd12;
      yr_shift  = yr1_r - 12'd1;
    end else begin
      mon_shift = mon_one;
      yr_shift  = yr1_r;
    end
    priority if (yr_shift >= CENTURY_YEAR) begin
      cent_q = 5'd20;
    end else if (yr_shift >= YEAR_MIN) begin
      cent_q = 5'd19;
    end else begin
      cent_q = 5'd18;
    end
    quad_q = (yr_shift >= CENTURY_YEAR) ? 3'd5 : 3'd4;
    yr_mod = (yr1_r >= CENTURY_YEAR) ? (yr1_r - CENTURY_YEAR) : (yr1_r - YEAR_MIN);

    sec2_nxt  = 7'(bcd2(7'(sec1_r)));
    min2_nxt  = 7'(bcd2(7'(min1_r)));
    hr2_nxt   = 6'(bcd2(7'(hr1_r)));
    day2_nxt  = 6'(bcd2(7'(day1_r)));
    mon2_nxt  = bcd2(7'(mon_one)) |
                ((yr1_r >= CENTURY_YEAR) ? CENTURY_FLAG : 8'h00);
    yrb2_nxt  = bcd2(yr_mod[6:0]);
    dsum2_nxt = 7'(day1_r) + {2'b00, mon_shift, 1'b0} + 7'(month_term(mon_shift));
    ysum2_nxt = yr_shift + {2'b00, yr_shift[11:2]} - 12'(cent_q) + 12'(quad_q);
  end

  always_comb begin
    sum3_nxt = ysum2_r + 12'(dsum2_r);
    fold1    = 5'(sum3_r[2:0]) + 5'(sum3_r[5:3]) + 5'(sum3_r[8:6]) + 5'(sum3_r[11:9]);
    fold2    = 4'(fold1[2:0]) + 4'(fold1[4:3]);
    mod7     = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    wd4_nxt  = (mod7 == 3'd6) ? 3'd0 : (mod7 + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      sec1_r <= sec1_nxt;
      min1_r <= min1_nxt;
      hr1_r  <= hr1_nxt;
      day1_r <= day1_nxt;
      mon1_r <= mon1_nxt;
      yr1_r  <= yr1_nxt;
    end
    if (adv2) begin
      sec2_r  <= sec2_nxt;
      min2_r  <= min2_nxt;
      hr2_r   <= hr2_nxt;
      day2_r  <= day2_nxt;
      mon2_r  <= mon2_nxt;
      yrb2_r  <= yrb2_nxt;
      dsum2_r <= dsum2_nxt;
      ysum2_r <= ysum2_nxt;
    end
    if (adv3) begin
      sec3_r <= sec2_r;
      min3_r <= min2_r;
      hr3_r  <= hr2_r;
      day3_r <= day2_r;
      mon3_r <= mon2_r;
      yrb3_r <= yrb2_r;
      sum3_r <= sum3_nxt;
    end
    if (adv4) begin
      sec4_r <= sec3_r;
      min4_r <= min3_r;
      hr4_r  <= hr3_r;
      day4_r <= day3_r;
      mon4_r <= mon3_r;
      yrb4_r <= yrb3_r;
      wd4_r  <= wd4_nxt;
    end
  end

  assign out_valid              = v4_r;
  assign out_second_bcd         = sec4_r;
  assign out_minute_bcd         = min4_r;
  assign out_hour_bcd           = hr4_r;
  assign out_day_bcd            = day4_r;
  assign out_weekday_code       = wd4_r;
  assign out_month_century_byte = mon4_r;
  assign out_year_bcd           = yrb4_r;

  `RDBE_ASSERT_SAME(a_stall_only_when_full, in_stall,
    v1_r && v2_r && v3_r && v4_r && out_stall, "input stalled with a free stage")
  `RDBE_ASSERT_NEXT(a_stage3_drains, v3_r && !v4_r, v4_r,
    "beat in stage three did not reach the output")
  `RDBE_ASSERT_SAME(a_weekday_range, v4_r, wd4_r != 3'd7, "weekday code out of range")
  `RDBE_ASSERT_SAME(a_month_digits, v4_r, mon4_r[6:5] == 2'b00 && mon4_r[3:0] <= 4'd9,
    "month byte is not BCD")

endmodule

// File: dv/rtc_date_bcd_encoder_test.sv
`timescale 1ns / 1ps
module rtc_date_bcd_encoder_test
  import rdbe_pkg::*;
;

  localparam int DATE_COUNT  = 1950;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month_zero_based;
    logic [11:0] full_year;
    bit          drain_first;
    bit          idle_ok;
  } date_beat_t;

  typedef struct packed {
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday_code;
    logic [7:0] month_century_byte;
    logic [7:0] year_bcd;
  } clock_regs_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        out_stall = 1'b0;
  date_beat_t  in_beat = '0;
  logic        in_stall;
  logic        out_valid;
  logic [5:0]  in_second;
  logic [5:0]  in_minute;
  logic [4:0]  in_hour;
  logic [4:0]  in_day_of_month;
  logic [3:0]  in_month_zero_based;
  logic [11:0] in_full_year;
  clock_regs_t got_regs;

  date_beat_t  pending_dates[$];
  clock_regs_t expected_regs[$];

  bit in_beat_taken = 1'b0;
  bit idle_ok_now = 1'b1;
  int in_gap_left = 0;
  int out_hold_left = 0;
  int quiet_cycles = 0;
  int dates_sent = 0;
  int regs_checked = 0;
  int mismatches = 0;

  assign in_second           = in_beat.second;
  assign in_minute           = in_beat.minute;
  assign in_hour             = in_beat.hour;
  assign in_day_of_month     = in_beat.day_of_month;
  assign in_month_zero_based = in_beat.month_zero_based;
  assign in_full_year        = in_beat.full_year;

  rtc_date_bcd_encoder i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_second              (in_second),
    .in_minute              (in_minute),
    .in_hour                (in_hour),
    .in_day_of_month        (in_day_of_month),
    .in_month_zero_based    (in_month_zero_based),
    .in_full_year           (in_full_year),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_second_bcd         (got_regs.second_bcd),
    .out_minute_bcd         (got_regs.minute_bcd),
    .out_hour_bcd           (got_regs.hour_bcd),
    .out_day_bcd            (got_regs.day_bcd),
    .out_weekday_code       (got_regs.weekday_code),
    .out_month_century_byte (got_regs.month_century_byte),
    .out_year_bcd           (got_regs.year_bcd)
  );

  function automatic logic [7:0] two_digit_bcd(input int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic clock_regs_t encode_date(input date_beat_t b);
    int unsigned sec, mnt, hr, day, mon, yr, m, y, w;
    clock_regs_t r;
    sec = (b.second > SEC_MAX) ? SEC_MAX : b.second;
    mnt = (b.minute > SEC_MAX) ? SEC_MAX : b.minute;
    hr  = (b.hour > HOUR_MAX) ? HOUR_MAX : b.hour;
    day = (b.day_of_month == 0) ? 1 : b.day_of_month;
    mon = (b.month_zero_based > MONTH_MAX) ? MONTH_MAX : b.month_zero_based;
    yr  = (b.full_year > YEAR_MAX) ? YEAR_MAX : b.full_year;
    if (yr < YEAR_MIN) begin
      yr = YEAR_MIN;
    end
    // January and February count as months 13 and 14 of the year before.
    m = mon + 1;
    y = yr;
    if (m <= 2) begin
      m = m + 12;
      y = y - 1;
    end
    w = (day + 2 * m + (3 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400) % 7;
    w = (w == 6) ? 0 : w + 1;
    r.second_bcd         = 7'(two_digit_bcd(sec));
    r.minute_bcd         = 7'(two_digit_bcd(mnt));
    r.hour_bcd           = 6'(two_digit_bcd(hr));
    r.day_bcd            = 6'(two_digit_bcd(day));
    r.weekday_code       = 3'(w);
    r.month_century_byte = two_digit_bcd(mon + 1) |
                           ((yr >= CENTURY_YEAR) ? CENTURY_FLAG : 8'h00);
    r.year_bcd           = two_digit_bcd(yr % 100);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic add_date(input int s, input int mi, input int h, input int d,
                          input int mo, input int yr);
    date_beat_t b;
    b = '0;
    b.second           = 6'(s);
    b.minute           = 6'(mi);
    b.hour             = 5'(h);
    b.day_of_month     = 5'(d);
    b.month_zero_based = 4'(mo);
    b.full_year        = 12'(yr);
    b.idle_ok          = 1'b1;
    pending_dates.push_back(b);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    date_beat_t nxt;
    if (rst_n) begin
      if (out_hold_left > 0) begin
        out_hold_left <= out_hold_left - 1;
        out_stall <= 1'b1;
      end else if (idle_ok_now && $urandom_range(0, 9) == 0) begin
        out_hold_left <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end

      if (!in_valid || in_beat_taken) begin
        if (in_gap_left > 0) begin
          in_gap_left <= in_gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_dates.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_dates[0].drain_first && (in_valid || expected_regs.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (idle_ok_now && $urandom_range(0, 7) == 0) begin
          in_gap_left <= $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_dates.pop_front();
          in_beat <= nxt;
          idle_ok_now <= nxt.idle_ok;
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    clock_regs_t want;
    bit moved;
    if (!rst_n) begin
      in_beat_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      moved = 1'b0;
      in_beat_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_regs.push_back(encode_date(in_beat));
        dates_sent++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_regs.size() == 0) begin
          mismatches++;
          $display("%0t: output beat with nothing expected, expected none, actual 0x%0h",
                   $time, got_regs);
        end else begin
          want = expected_regs.pop_front();
          regs_checked++;
          check_field("second_bcd", want.second_bcd, got_regs.second_bcd);
          check_field("minute_bcd", want.minute_bcd, got_regs.minute_bcd);
          check_field("hour_bcd", want.hour_bcd, got_regs.hour_bcd);
          check_field("day_bcd", want.day_bcd, got_regs.day_bcd);
          check_field("weekday_code", want.weekday_code, got_regs.weekday_code);
          check_field("month_century_byte", want.month_century_byte,
                      got_regs.month_century_byte);
          check_field("year_bcd", want.year_bcd, got_regs.year_bcd);
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    date_beat_t b;
    int n;
    add_date(0, 0, 0, 0, 0, 0);
    add_date(63, 63, 31, 31, 15, 4095);
    add_date(59, 59, 23, 31, 11, 2099);
    add_date(60, 60, 24, 1, 12, 2100);
    add_date(0, 0, 0, 1, 0, 1900);
    add_date(30, 45, 12, 1, 0, 1899);
    add_date(59, 59, 23, 31, 11, 1999);
    add_date(0, 0, 0, 1, 0, 2000);
    add_date(12, 34, 5, 29, 1, 2000);
    add_date(7, 8, 9, 31, 1, 2023);
    add_date(10, 20, 13, 28, 1, 1900);
    add_date(0, 0, 0, 1, 2, 2000);
    add_date(1, 1, 1, 10, 3, 2048);
    for (int mo = 3; mo <= 10; mo++) begin
      add_date(mo * 5, mo * 4, mo, 15, mo, 2024);
    end
    n = pending_dates.size();
    for (int i = n; i < DATE_COUNT; i++) begin
      b = '0;
      b.second = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
      b.minute = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
      b.hour = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
      b.day_of_month = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
      b.month_zero_based = ($urandom_range(0, 7) == 0) ? 4'($urandom) :
                           4'($urandom_range(0, 11));
      b.full_year = ($urandom_range(0, 7) == 0) ? 12'($urandom) :
                    12'($urandom_range(1900, 2099));
      b.drain_first = (i % 400 == 200);
      b.idle_ok = !((i >= 700 && i < 900) || i >= DATE_COUNT - 200);
      pending_dates.push_back(b);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_dates.size() != 0 || in_valid || expected_regs.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d dates, checked %0d register sets (clamped and raw fields, both centuries,",
             dates_sent, regs_checked);
    $display("leap and past-end days), with random input gaps and output stalls; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_regs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
